// ===== src/lvt_pkg.sv =====
`default_nettype none

package lvt_pkg;

    // Field widths of the request and response transactions.
    localparam int OP_W      = 2;
    localparam int ID_W      = 6;
    localparam int LIMIT_W   = 7;
    localparam int COUNT_W   = 7;

    // Default number of tracked frames and the reset value of the limit register.
    localparam int               NUM_FRAMES_DEF = 64;
    localparam logic [LIMIT_W-1:0] LIMIT_RST    = 7'd64;

    // Operation codes carried by a request.
    typedef enum logic [OP_W-1:0] {
        OP_UNPIN  = 2'd0,
        OP_PIN    = 2'd1,
        OP_VICTIM = 2'd2
    } t_op;

    // Command broadcast from the control logic to every cell of the chain.
    typedef struct packed {
        logic            load;   // append id at the first empty cell
        logic            pin;    // remove the cell holding id
        logic            evict;  // remove the head cell
        logic [ID_W-1:0] id;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== src/lvt_in_if.sv =====
`default_nettype none

interface lvt_in_if;
    import lvt_pkg::*;

    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] frame_num;

    modport source (output valid, output operation, output frame_num, input ready);
    modport sink   (input valid, input operation, input frame_num, output ready);
endinterface

`default_nettype wire

// ===== src/lvt_out_if.sv =====
`default_nettype none

interface lvt_out_if;
    import lvt_pkg::*;

    logic               valid;
    logic               ready;
    logic               victim_found;
    logic [ID_W-1:0]    victim_frame;
    logic [COUNT_W-1:0] evictable_count;
    logic               bad_frame;

    modport source (output valid, output victim_found, output victim_frame,
                    output evictable_count, output bad_frame, input ready);
    modport sink   (input valid, input victim_found, input victim_frame,
                    input evictable_count, input bad_frame, output ready);
endinterface

`default_nettype wire

// ===== src/lvt_cell.sv =====
`default_nettype none

module lvt_cell
    import lvt_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cell_cmd       i_cmd,
    input  wire logic            i_prev_valid,
    input  wire logic            i_shift_in,
    input  wire logic            i_next_valid,
    input  wire logic [ID_W-1:0] i_next_id,
    output logic                 o_valid,
    output logic [ID_W-1:0]      o_id,
    output logic                 o_match,
    output logic                 o_shift_out
);

    logic            r_valid;
    logic [ID_W-1:0] r_id;
    logic            n_valid;
    logic [ID_W-1:0] n_id;
    logic            take_new;

    // A cell matches when it holds the requested frame.
    assign o_match = r_valid && (r_id == i_cmd.id);

    // Once a removal point is passed, every cell to its right moves one place left.
    assign o_shift_out = i_shift_in || (i_cmd.pin && o_match);

    // An append lands in the first empty cell: left neighbor full, this one empty.
    assign take_new = i_cmd.load && i_prev_valid && !r_valid;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        if (o_shift_out) begin
            n_valid = i_next_valid;
            n_id    = i_next_id;
        end else if (take_new) begin
            n_valid = 1'b1;
            n_id    = i_cmd.id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;

endmodule

`default_nettype wire

// ===== src/lvt_chain.sv =====
`default_nettype none

module lvt_chain
    import lvt_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_cmd  i_cmd,
    output logic            o_head_valid,
    output logic [ID_W-1:0] o_head_id,
    output logic            o_present
);

    logic [NUM_FRAMES-1:0] cell_valid;
    logic [ID_W-1:0]       cell_id [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] cell_match;
    logic [NUM_FRAMES-1:0] cell_shift;

    // Row of cells ordered from least recent (cell 0) to most recent.
    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
        logic            prev_valid;
        logic            shift_in;
        logic            next_valid;
        logic [ID_W-1:0] next_id;

        if (g == 0) begin : g_head
            assign prev_valid = 1'b1;
            assign shift_in   = i_cmd.evict;
        end else begin : g_body
            assign prev_valid = cell_valid[g-1];
            assign shift_in   = cell_shift[g-1];
        end

        if (g == NUM_FRAMES - 1) begin : g_tail
            assign next_valid = 1'b0;
            assign next_id    = i_cmd.id;
        end else begin : g_link
            assign next_valid = cell_valid[g+1];
            assign next_id    = cell_id[g+1];
        end

        lvt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (i_cmd),
            .i_prev_valid (prev_valid),
            .i_shift_in   (shift_in),
            .i_next_valid (next_valid),
            .i_next_id    (next_id),
            .o_valid      (cell_valid[g]),
            .o_id         (cell_id[g]),
            .o_match      (cell_match[g]),
            .o_shift_out  (cell_shift[g])
        );
    end

    assign o_head_valid = cell_valid[0];
    assign o_head_id    = cell_id[0];
    assign o_present    = |cell_match;

endmodule

`default_nettype wire

// ===== src/lru_victim_tracker.sv =====
`default_nettype none

// A result is held in the output register from the cycle after its request is taken.
// One transaction per cycle while the response side keeps up; every cell of the chain updates in the same cycle.
// The request side stalls only while a result waits and the response side is not ready.
// Reset (synchronous, active low): the list is empty, the count is zero and the limit is 64.

module lru_victim_tracker
    import lvt_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [LIMIT_W-1:0] i_cfg_data,
    lvt_in_if.sink                  i_req,
    lvt_out_if.source               o_rsp
);

    localparam int CW   = $clog2(NUM_FRAMES + 1);
    localparam int CMPW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;
    localparam int SUMW = CW + COUNT_W;

    logic [LIMIT_W-1:0] r_frame_limit;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;

    logic               r_out_valid;
    logic               r_found;
    logic [ID_W-1:0]    r_victim;
    logic [COUNT_W-1:0] r_count_out;
    logic               r_bad;

    logic               accept;
    logic               is_unpin;
    logic               is_pin;
    logic               is_victim;
    logic [CMPW-1:0]    limit_ext;
    logic [CMPW-1:0]    frames_ext;
    logic [CMPW-1:0]    eff_limit;
    logic               id_bad;
    logic               bad;
    logic               head_valid;
    logic [ID_W-1:0]    head_id;
    logic               present;
    logic               grow;
    logic               shrink;
    logic [SUMW-1:0]    count_wide;
    t_cell_cmd          cmd;

    // Limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= LIMIT_RST;
        end else if (i_cfg_we) begin
            r_frame_limit <= i_cfg_data;
        end
    end

    // Request handshake: take a new transaction unless a result is stuck.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    // Operation decode.
    always_comb begin
        is_unpin  = 1'b0;
        is_pin    = 1'b0;
        is_victim = 1'b0;
        case (i_req.operation)
            OP_UNPIN:  is_unpin  = 1'b1;
            OP_PIN:    is_pin    = 1'b1;
            OP_VICTIM: is_victim = 1'b1;
            default:   ;
        endcase
    end

    // Range check against the smaller of the register and the chain length.
    assign limit_ext  = CMPW'(r_frame_limit);
    assign frames_ext = CMPW'(NUM_FRAMES);
    assign eff_limit  = (limit_ext < frames_ext) ? limit_ext : frames_ext;
    assign id_bad     = CMPW'(i_req.frame_num) >= eff_limit;
    assign bad        = (is_unpin || is_pin) && id_bad;

    // Command to the cell chain.
    assign grow      = accept && is_unpin && !id_bad && !present && (r_count < CW'(NUM_FRAMES));
    assign cmd.load  = grow;
    assign cmd.pin   = accept && is_pin && !id_bad;
    assign cmd.evict = accept && is_victim && head_valid;
    assign cmd.id    = i_req.frame_num;

    lvt_chain #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_head_valid (head_valid),
        .o_head_id    (head_id),
        .o_present    (present)
    );

    // Count of listed frames.
    assign shrink = (cmd.pin && present) || cmd.evict;

    always_comb begin
        n_count = r_count;
        if (grow) begin
            n_count = r_count + CW'(1);
        end else if (shrink) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign count_wide = SUMW'(n_count);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_found     <= cmd.evict;
            r_victim    <= cmd.evict ? head_id : '0;
            r_count_out <= count_wide[COUNT_W-1:0];
            r_bad       <= bad;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.victim_found    = r_found;
    assign o_rsp.victim_frame    = r_victim;
    assign o_rsp.evictable_count = r_count_out;
    assign o_rsp.bad_frame       = r_bad;

endmodule

`default_nettype wire
